// File: hdl/ascon_pkg.sv
// shared types, constants and the round constant table of the ascon aead core
package ascon_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ROUND_W   = 4;

    localparam logic [WORD_W-1:0] IV_WORD    = 64'h80400c0600000000;
    localparam logic [WORD_W-1:0] DOMAIN_BIT = 64'h0000000000000001;

    // round index of the first round of p12 and p6, and of the last round of both
    localparam logic [ROUND_W-1:0] P12_FIRST  = 4'd0;
    localparam logic [ROUND_W-1:0] P6_FIRST   = 4'd6;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd11;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    typedef enum logic [2:0] {
        CMD_INIT     = 3'd0,
        CMD_ABSORB   = 3'd1,
        CMD_CLOSE_AD = 3'd2,
        CMD_ENCRYPT  = 3'd3,
        CMD_DECRYPT  = 3'd4,
        CMD_FINALIZE = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } t_state;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_perm;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] data_in;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic        last_block;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] data_out;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               post_key;
        logic               out_load;
        logic               out_tag;
        logic               out_from_next;
    } t_dp_cmd;

    function automatic logic [7:0] round_const(input logic [ROUND_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = 8'hf0;
            4'd1:    c = 8'he1;
            4'd2:    c = 8'hd2;
            4'd3:    c = 8'hc3;
            4'd4:    c = 8'hb4;
            4'd5:    c = 8'ha5;
            4'd6:    c = 8'h96;
            4'd7:    c = 8'h87;
            4'd8:    c = 8'h78;
            4'd9:    c = 8'h69;
            4'd10:   c = 8'h5a;
            4'd11:   c = 8'h4b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/ascon_dp.sv
// datapath of the ascon aead core: permutation state, key, round logic, result register
module ascon_dp
    import ascon_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_dp,
    input  t_in                  i_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output t_out                 o_out
);

    t_perm r_s, n_s, round_out;
    t_word r_key_high, r_key_low;
    t_word r_word, n_word;
    t_out  r_out;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // one round: constant addition, s-box layer, linear layer
    function automatic t_perm perm_round(input t_perm s, input logic [7:0] c);
        t_word x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        t_perm r;
        x2 = s[2] ^ {56'd0, c};
        x0 = s[0] ^ s[4];
        x4 = s[4] ^ s[3];
        x2 = x2 ^ s[1];
        x1 = s[1];
        x3 = s[3];
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
        r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
        return r;
    endfunction

    always_comb begin
        round_out = perm_round(r_s, round_const(i_dp.round_idx));
        if (i_dp.post_key) begin
            round_out[3] = round_out[3] ^ r_key_high;
            round_out[4] = round_out[4] ^ r_key_low;
        end
    end

    // state update: command pre-processing on load, one round while round_en is set, hold otherwise
    always_comb begin
        n_s    = r_s;
        n_word = r_word;
        if (i_dp.load) begin
            unique case (i_in.cmd)
                CMD_INIT: begin
                    n_s[0] = IV_WORD;
                    n_s[1] = r_key_high;
                    n_s[2] = r_key_low;
                    n_s[3] = i_in.nonce_high;
                    n_s[4] = i_in.nonce_low;
                end
                CMD_ABSORB: n_s[0] = r_s[0] ^ i_in.data_in;
                CMD_CLOSE_AD: n_s[4] = r_s[4] ^ DOMAIN_BIT;
                CMD_ENCRYPT: begin
                    n_word = r_s[0] ^ i_in.data_in;
                    n_s[0] = r_s[0] ^ i_in.data_in;
                end
                CMD_DECRYPT: begin
                    n_word = r_s[0] ^ i_in.data_in;
                    n_s[0] = i_in.data_in;
                end
                CMD_FINALIZE: begin
                    n_s[1] = r_s[1] ^ r_key_high;
                    n_s[2] = r_s[2] ^ r_key_low;
                end
                default: ;
            endcase
        end else if (i_dp.round_en) begin
            n_s = round_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s        <= '0;
            r_key_high <= '0;
            r_key_low  <= '0;
        end else begin
            r_s <= n_s;
            if (i_cfg_we && i_cfg_index == CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (i_dp.out_load) begin
            r_out.result_kind <= i_dp.out_tag;
            r_out.data_out    <= i_dp.out_tag ? '0 : r_word;
            if (!i_dp.out_tag) begin
                r_out.tag_high <= '0;
                r_out.tag_low  <= '0;
            end else if (i_dp.out_from_next) begin
                r_out.tag_high <= n_s[3];
                r_out.tag_low  <= n_s[4];
            end else begin
                r_out.tag_high <= r_s[3];
                r_out.tag_low  <= r_s[4];
            end
        end
    end

    assign o_out = r_out;

endmodule

// File: hdl/ascon_ctrl.sv
// controller of the ascon aead core: command sequencing, round counter, result handshake
module ascon_ctrl
    import ascon_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic [2:0] i_cmd,
    input  logic    i_last,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_dp
);

    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_emit, n_emit;
    logic               r_post, n_post;
    logic               r_out_valid;
    logic               accept, slot_free;
    logic               dec_rounds, dec_emit, dec_post;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // command decode at the input
    assign dec_post   = (i_cmd == CMD_INIT) || (i_cmd == CMD_FINALIZE);
    assign dec_emit   = (i_cmd == CMD_ENCRYPT) || (i_cmd == CMD_DECRYPT)
                     || (i_cmd == CMD_FINALIZE);
    assign dec_rounds = dec_post || (i_cmd == CMD_ABSORB)
                     || (((i_cmd == CMD_ENCRYPT) || (i_cmd == CMD_DECRYPT)) && !i_last);

    // next state
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_emit  = r_emit;
        n_post  = r_post;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_emit  = dec_emit;
                    n_post  = dec_post;
                    n_round = dec_post ? P12_FIRST : P6_FIRST;
                    if (dec_rounds) begin
                        n_state = ST_ROUND;
                    end else if (dec_emit) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    if (r_emit && !slot_free) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_dp.load          = accept;
        o_dp.round_en      = (r_state == ST_ROUND);
        o_dp.round_idx     = r_round;
        o_dp.post_key      = (r_state == ST_ROUND) && r_post && (r_round == LAST_ROUND);
        o_dp.out_tag       = r_post;
        o_dp.out_from_next = (r_state == ST_ROUND);
        o_dp.out_load      = 1'b0;
        unique case (r_state)
            ST_ROUND: o_dp.out_load = r_emit && (r_round == LAST_ROUND) && slot_free;
            ST_EMIT:  o_dp.out_load = slot_free;
            default:  o_dp.out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_emit      <= 1'b0;
            r_post      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_emit  <= n_emit;
            r_post  <= n_post;
            if (o_dp.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_round_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round <= LAST_ROUND))
        else $error("round counter past the last round");

    a_close_ad_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_CLOSE_AD) |=> (r_state == ST_IDLE))
        else $error("close-ad did not return to idle");

    a_emit_only_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_emit)
        else $error("waiting to emit for a command without result");

    a_post_key_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp.post_key |=> (r_state != ST_ROUND))
        else $error("key added before the final round");

endmodule

// File: hdl/ascon_aead_cipher_core.sv
// top level of the ascon-128 style aead core: controller plus datapath
//
// usage
// - input channel (i_in_valid / o_in_ready / i_in_data) carries one command
//   per transaction: init, absorb ad, close ad, encrypt, decrypt, finalize
// - output channel (o_out_valid / i_out_ready / o_out_data) carries one
//   transaction for encrypt, decrypt (data word) and finalize (tag)
// - config channel (i_cfg_valid / o_cfg_ready) writes key_high (index 0) and
//   key_low (index 1); always ready, other indexes are dropped
// - one permutation round per cycle in a single shared round unit, so the
//   round count sets the item time: absorb and non-last data blocks run p6,
//   init and finalize run p12, close ad, a last data block and unused
//   command codes run no rounds
// - a result is registered; with the result register free it shows on the
//   port the cycle after the last round; a last data block emits from ST_EMIT
// - the block takes a new command while a result still waits; if the receiver
//   stalls and a second result is due, the block holds it until the result
//   register frees up, with input ready low meanwhile
// - synchronous reset clears the state words, key, control and output valid
module ascon_aead_cipher_core
    import ascon_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_dp_cmd dp_cmd;

    // key registers take writes at any time; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    ascon_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_in_data.cmd),
        .i_last      (i_in_data.last_block),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_dp        (dp_cmd)
    );

    ascon_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp        (dp_cmd),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out_data)
    );

endmodule
